@@ rtl/core/mmfn_pkg.sv @@
// Shared types and constants for the min-max feature normalizer.
package mmfn_pkg;

    localparam int CFG_W   = 5;
    localparam int SCALE_W = 16;
    localparam logic [SCALE_W-1:0] SCALE_ONE = '1;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_LD_WR,
        FE_MOD,
        FE_RO_RD,
        FE_RO_PUSH
    } t_fe_state;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_DIFF,
        BE_NUM,
        BE_DIV,
        BE_OUT
    } t_be_state;

    typedef struct packed {
        logic last;
        logic dropped;
    } t_ro_flags;

endpackage

@@ rtl/core/mmfn_queue.sv @@
// Two-entry queue between the front and back parts.
module mmfn_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    output logic         o_push_ready,
    output logic         o_pop_valid,
    output logic [W-1:0] o_pop_data,
    input  logic         i_pop
);
    import mmfn_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         push_ok;
    logic         pop_ok;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push_ok      = i_push && o_push_ready;
    assign pop_ok       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push_ok) - 2'(pop_ok);
        end
    end

endmodule

@@ rtl/core/mmfn_front.sv @@
// Front part: takes beats, keeps the sample store and the per-feature min/max.
module mmfn_front #(
    parameter int MAX_FEATURES = 16,
    parameter int STORE_DEPTH  = 4096,
    parameter int SAMPLE_BITS  = 16,
    parameter int FI_W         = 4,
    parameter int E_W          = 54
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mmfn_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                         o_push,
    output logic [E_W-1:0]               o_push_data,
    input  logic                         i_push_ready
);
    import mmfn_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int FC_W   = $clog2(MAX_FEATURES + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int MS_W   = $clog2(ADDR_W);
    localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

    t_fe_state            r_state, n_state;
    logic [CFG_W-1:0]     r_feature_count;
    logic [CNT_W-1:0]     r_loaded_count, n_loaded_count;
    logic [CNT_W-1:0]     r_readout_count, n_readout_count;
    logic [FC_W-1:0]      r_ld_pos, n_ld_pos;
    logic                 r_overflow, n_overflow;
    logic [FI_W-1:0]      r_ld_p, n_ld_p;
    logic signed [SB-1:0] r_ld_x, n_ld_x;
    logic [FC_W-1:0]      r_mrem, n_mrem;
    logic [ADDR_W-1:0]    r_mq, n_mq;
    logic [MS_W-1:0]      r_mstep, n_mstep;
    logic [MAX_FEATURES-1:0] r_mm_valid;

    // sample store
    logic signed [SB-1:0] r_store [STORE_DEPTH];
    logic signed [SB-1:0] r_st_rd;
    logic                 st_we;
    logic                 st_rd;

    // min/max store, {max, min} per feature
    logic [2*SB-1:0]      r_mm [MAX_FEATURES];
    logic [2*SB-1:0]      r_mm_rd;
    logic                 r_mm_rd_valid;
    logic                 mm_rd;
    logic [FI_W-1:0]      mm_rd_addr;
    logic                 mm_we;
    logic [2*SB-1:0]      mm_wdata;

    logic                 set_clear;
    logic [FC_W-1:0]      fc;
    logic signed [SB-1:0] cur_min;
    logic signed [SB-1:0] cur_max;
    t_ro_flags            flags;

    always_comb begin
        if (r_feature_count == '0) begin
            fc = FC_W'(1);
        end else if (int'(r_feature_count) > MAX_FEATURES) begin
            fc = FC_W'(MAX_FEATURES);
        end else begin
            fc = FC_W'(r_feature_count);
        end
    end

    // stored entry of a feature never touched in this set reads as the reset value
    assign cur_max = r_mm_rd_valid ? r_mm_rd[2*SB-1:SB] : SMP_MIN;
    assign cur_min = r_mm_rd_valid ? r_mm_rd[SB-1:0]    : SMP_MAX;

    assign flags.last    = ((r_readout_count + CNT_W'(1)) == r_loaded_count);
    assign flags.dropped = r_overflow;
    assign o_push_data   = {r_st_rd, cur_min, cur_max, r_mrem[FI_W-1:0], flags};
    assign o_ready       = (r_state == FE_IDLE);

    always_comb begin
        logic [FC_W-1:0] p;
        logic [FC_W:0]   p_inc;
        logic [FC_W:0]   sh;
        logic signed [SB-1:0] new_min;
        logic signed [SB-1:0] new_max;

        n_state         = r_state;
        n_loaded_count  = r_loaded_count;
        n_readout_count = r_readout_count;
        n_ld_pos        = r_ld_pos;
        n_overflow      = r_overflow;
        n_ld_p          = r_ld_p;
        n_ld_x          = r_ld_x;
        n_mrem          = r_mrem;
        n_mq            = r_mq;
        n_mstep         = r_mstep;
        st_we           = 1'b0;
        st_rd           = 1'b0;
        mm_rd           = 1'b0;
        mm_rd_addr      = r_mrem[FI_W-1:0];
        mm_we           = 1'b0;
        mm_wdata        = {cur_max, cur_min};
        o_push          = 1'b0;
        set_clear       = 1'b0;
        p               = '0;
        p_inc           = '0;
        sh              = '0;
        new_min         = cur_min;
        new_max         = cur_max;

        unique case (r_state)
            FE_IDLE: begin
                if (i_valid) begin
                    if (!i_cmd) begin
                        if (r_loaded_count >= CNT_W'(STORE_DEPTH)) begin
                            n_overflow = 1'b1;
                        end else begin
                            p              = (r_ld_pos >= fc) ? '0 : r_ld_pos;
                            p_inc          = {1'b0, p} + (FC_W+1)'(1);
                            st_we          = 1'b1;
                            n_loaded_count = r_loaded_count + CNT_W'(1);
                            n_ld_pos       = (p_inc >= {1'b0, fc}) ? '0 : p_inc[FC_W-1:0];
                            n_ld_p         = p[FI_W-1:0];
                            n_ld_x         = i_sample;
                            mm_rd          = 1'b1;
                            mm_rd_addr     = p[FI_W-1:0];
                            n_state        = FE_LD_WR;
                        end
                    end else if (r_readout_count < r_loaded_count) begin
                        st_rd   = 1'b1;
                        n_mq    = r_readout_count[ADDR_W-1:0];
                        n_mrem  = '0;
                        n_mstep = MS_W'(ADDR_W - 1);
                        n_state = FE_MOD;
                    end
                end
            end
            FE_LD_WR: begin
                new_max  = (r_ld_x > cur_max) ? r_ld_x : cur_max;
                new_min  = (r_ld_x < cur_min) ? r_ld_x : cur_min;
                mm_we    = 1'b1;
                mm_wdata = {new_max, new_min};
                n_state  = FE_IDLE;
            end
            FE_MOD: begin
                // restoring remainder: readout index modulo feature count, MSB first
                sh = {r_mrem, r_mq[ADDR_W-1]};
                if (sh >= {1'b0, fc}) begin
                    sh = sh - {1'b0, fc};
                end
                n_mrem = sh[FC_W-1:0];
                n_mq   = r_mq << 1;
                if (r_mstep == '0) begin
                    n_state = FE_RO_RD;
                end else begin
                    n_mstep = r_mstep - MS_W'(1);
                end
            end
            FE_RO_RD: begin
                mm_rd   = 1'b1;
                n_state = FE_RO_PUSH;
            end
            FE_RO_PUSH: begin
                o_push = 1'b1;
                if (i_push_ready) begin
                    n_readout_count = r_readout_count + CNT_W'(1);
                    set_clear       = flags.last;
                    n_state         = FE_IDLE;
                end
            end
            default: begin
                n_state = FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[r_loaded_count[ADDR_W-1:0]] <= i_sample;
        end
        if (st_rd) begin
            r_st_rd <= r_store[r_readout_count[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mm_we) begin
            r_mm[r_ld_p] <= mm_wdata;
        end
        if (mm_rd) begin
            r_mm_rd       <= r_mm[mm_rd_addr];
            r_mm_rd_valid <= r_mm_valid[mm_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_p  <= n_ld_p;
        r_ld_x  <= n_ld_x;
        r_mrem  <= n_mrem;
        r_mq    <= n_mq;
        r_mstep <= n_mstep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= FE_IDLE;
            r_feature_count <= CFG_W'(1);
            r_loaded_count  <= '0;
            r_readout_count <= '0;
            r_ld_pos        <= '0;
            r_overflow      <= 1'b0;
            r_mm_valid      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_feature_count <= i_cfg_wdata;
            end
            if (set_clear) begin
                r_loaded_count  <= '0;
                r_readout_count <= '0;
                r_ld_pos        <= '0;
                r_overflow      <= 1'b0;
                r_mm_valid      <= '0;
            end else begin
                r_loaded_count  <= n_loaded_count;
                r_readout_count <= n_readout_count;
                r_ld_pos        <= n_ld_pos;
                r_overflow      <= n_overflow;
                if (mm_we) begin
                    r_mm_valid[r_ld_p] <= 1'b1;
                end
            end
        end
    end

    a_ro_le_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_readout_count <= r_loaded_count)
        else $error("readout count passed loaded count");

    a_ld_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded_count <= CNT_W'(STORE_DEPTH))
        else $error("loaded count beyond store depth");

    a_mod_lt_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FE_RO_RD) |-> (r_mrem < fc))
        else $error("feature position not below feature count");

endmodule

@@ rtl/core/mmfn_back.sv @@
// Back part: range checks and iterative divide for one read-out, result register.
module mmfn_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int FI_W        = 4,
    parameter int E_W         = 54
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic [E_W-1:0]                i_q_data,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mmfn_pkg::SCALE_W-1:0]  o_scaled_value,
    output logic [FI_W-1:0]               o_feature_index,
    output logic                          o_last_value,
    output logic                          o_dropped
);
    import mmfn_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int NUM_W = SB + SCALE_W;
    localparam int ST_W = $clog2(SCALE_W);

    t_be_state            r_state, n_state;
    logic signed [SB-1:0] r_x, r_mn, r_mx;
    logic [FI_W-1:0]      r_f;
    t_ro_flags            r_flags;
    logic [SB-1:0]        r_range, n_range;
    logic [SB-1:0]        r_d, n_d;
    logic [SB-1:0]        r_rem, n_rem;
    logic [SCALE_W-1:0]   r_low, n_low;
    logic [ST_W-1:0]      r_step, n_step;
    logic [SCALE_W-1:0]   r_scaled, n_scaled;

    logic signed [SB-1:0] q_x, q_mn, q_mx;
    logic [FI_W-1:0]      q_f;
    t_ro_flags            q_flags;

    assign {q_x, q_mn, q_mx, q_f, q_flags} = i_q_data;

    assign o_scaled_value  = r_scaled;
    assign o_feature_index = r_f;
    assign o_last_value    = r_flags.last;
    assign o_dropped       = r_flags.dropped;

    always_comb begin
        logic signed [SB:0] diff_r;
        logic signed [SB:0] diff_d;
        logic [NUM_W-1:0]   num;
        logic [SB:0]        sh;
        logic               qbit;

        n_state  = r_state;
        n_range  = r_range;
        n_d      = r_d;
        n_rem    = r_rem;
        n_low    = r_low;
        n_step   = r_step;
        n_scaled = r_scaled;
        o_q_pop  = 1'b0;
        o_valid  = 1'b0;
        diff_r   = {r_mx[SB-1], r_mx} - {r_mn[SB-1], r_mn};
        diff_d   = {r_x[SB-1], r_x} - {r_mn[SB-1], r_mn};
        num      = {r_d, {SCALE_W{1'b0}}} - NUM_W'(r_d) + NUM_W'(r_range >> 1);
        sh       = {r_rem, r_low[SCALE_W-1]};
        qbit     = (sh >= {1'b0, r_range});

        unique case (r_state)
            BE_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = BE_DIFF;
                end
            end
            BE_DIFF: begin
                // flat feature and out-of-range samples skip the divide
                if (r_mx > r_mn) begin
                    if (r_x <= r_mn) begin
                        n_scaled = '0;
                        n_state  = BE_OUT;
                    end else if (r_x >= r_mx) begin
                        n_scaled = SCALE_ONE;
                        n_state  = BE_OUT;
                    end else begin
                        n_range = diff_r[SB-1:0];
                        n_d     = diff_d[SB-1:0];
                        n_state = BE_NUM;
                    end
                end else begin
                    n_scaled = '0;
                    n_state  = BE_OUT;
                end
            end
            BE_NUM: begin
                // d*65535 + range/2; the quotient fits 16 bits so the top part is below range
                n_rem   = num[NUM_W-1:SCALE_W];
                n_low   = num[SCALE_W-1:0];
                n_step  = ST_W'(SCALE_W - 1);
                n_state = BE_DIV;
            end
            BE_DIV: begin
                if (qbit) begin
                    sh = sh - {1'b0, r_range};
                end
                n_rem = sh[SB-1:0];
                n_low = {r_low[SCALE_W-2:0], qbit};
                if (r_step == '0) begin
                    n_scaled = n_low;
                    n_state  = BE_OUT;
                end else begin
                    n_step = r_step - ST_W'(1);
                end
            end
            BE_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = BE_IDLE;
                end
            end
            default: begin
                n_state = BE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_x     <= q_x;
            r_mn    <= q_mn;
            r_mx    <= q_mx;
            r_f     <= q_f;
            r_flags <= q_flags;
        end
        r_range  <= n_range;
        r_d      <= n_d;
        r_rem    <= n_rem;
        r_low    <= n_low;
        r_step   <= n_step;
        r_scaled <= n_scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_rem_lt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BE_DIV) |-> (r_rem < r_range))
        else $error("partial remainder not below range");

    a_d_lt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BE_NUM) |-> (r_d < r_range))
        else $error("offset not below range");

endmodule

@@ rtl/core/min_max_feature_normalizer_unit.sv @@
// Top level of the min-max feature normalizer.
// Load beats (cmd 0) write a sample into the store and update its feature's min and max. A
// read-out beat (cmd 1) passes the front part, whose main work is the 12-step (log2 of the
// store depth) remainder loop that finds the feature position; then, for a sample inside the
// range, the back part runs the 16-step restoring divider before the result beat is offered.
// A two-entry queue sits between the parts, so the front takes new beats while the back divides
// or waits on the output, as long as the queue has room; the back takes its next read-out only
// once its result beat is taken. A read-out with nothing left to read gives no result; the final
// read-out of a set clears the counters, the drop flag and the min/max state at once, no sweep.
module min_max_feature_normalizer_unit #(
    parameter int MAX_FEATURES = 16,
    parameter int STORE_DEPTH  = 4096,
    parameter int SAMPLE_BITS  = 16,
    parameter int FI_W         = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mmfn_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mmfn_pkg::SCALE_W-1:0]  o_scaled_value,
    output logic [FI_W-1:0]               o_feature_index,
    output logic                          o_last_value,
    output logic                          o_dropped
);
    import mmfn_pkg::*;

    localparam int E_W = 3 * SAMPLE_BITS + FI_W + $bits(t_ro_flags);

    logic           push;
    logic [E_W-1:0] push_data;
    logic           push_ready;
    logic           pop_valid;
    logic [E_W-1:0] pop_data;
    logic           pop;

    mmfn_front #(
        .MAX_FEATURES (MAX_FEATURES),
        .STORE_DEPTH  (STORE_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FI_W         (FI_W),
        .E_W          (E_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_sample     (i_sample),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    mmfn_queue #(
        .W (E_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop        (pop)
    );

    mmfn_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FI_W        (FI_W),
        .E_W         (E_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (pop_valid),
        .i_q_data        (pop_data),
        .o_q_pop         (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_scaled_value  (o_scaled_value),
        .o_feature_index (o_feature_index),
        .o_last_value    (o_last_value),
        .o_dropped       (o_dropped)
    );

endmodule

@@ verif/min_max_feature_normalizer_unit_tb.sv @@
// Self-checking testbench for the min-max feature normalizer: random beats, scoreboard on results.
`timescale 1ns / 1ps

module min_max_feature_normalizer_unit_tb;

    import mmfn_pkg::*;

    localparam int NUM_FEAT      = 16;
    localparam int STORE_SIZE    = 4096;
    localparam int RAND_ITEMS    = 1550;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int WDOG_LIMIT    = 3000;
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_READ,
        OP_CFG
    } t_op;

    typedef enum logic [1:0] {
        SM_FULL,
        SM_NEAR,
        SM_FLAT,
        SM_EDGE
    } t_smp_mode;

    typedef struct {
        t_op                op;
        logic signed [15:0] smp;
        logic [CFG_W-1:0]   cfg;
        bit                 hold;
    } t_beat;

    typedef struct {
        logic [SCALE_W-1:0] scaled;
        logic [3:0]         fidx;
        logic               last;
        logic               dropped;
    } t_norm_res;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               i_valid     = 1'b0;
    logic               i_cmd       = 1'b0;
    logic signed [15:0] i_sample    = '0;
    logic               i_ready     = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [SCALE_W-1:0] o_scaled_value;
    logic [3:0]         o_feature_index;
    logic               o_last_value;
    logic               o_dropped;

    t_beat     beats_q[$];
    t_norm_res norm_results_q[$];
    int        err_cnt = 0;
    int        n_items = 0;

    // normalizer state as the scoreboard sees it
    logic signed [15:0] m_store [STORE_SIZE];
    logic signed [15:0] m_max [NUM_FEAT];
    logic signed [15:0] m_min [NUM_FEAT];
    int unsigned        m_loaded;
    int unsigned        m_readout;
    int unsigned        m_pos;
    logic               m_overflow;
    logic [CFG_W-1:0]   m_fcount;

    min_max_feature_normalizer_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_scaled_value  (o_scaled_value),
        .o_feature_index (o_feature_index),
        .o_last_value    (o_last_value),
        .o_dropped       (o_dropped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_set();
        for (int f = 0; f < NUM_FEAT; f++) begin
            m_max[f] = 16'sh8000;
            m_min[f] = 16'sh7FFF;
        end
        m_loaded   = 0;
        m_readout  = 0;
        m_pos      = 0;
        m_overflow = 1'b0;
    endtask

    // Update the tracked state with one accepted beat; queue the result a read-out yields.
    task automatic normalize_beat(input logic cmd, input logic signed [15:0] x);
        int unsigned fc;
        int unsigned p;
        int unsigned idx;
        longint      xv;
        longint      mn;
        longint      mx;
        longint      rng;
        longint      q;
        t_norm_res   r;
        fc = (m_fcount == 0) ? 1 : (m_fcount > NUM_FEAT) ? NUM_FEAT : m_fcount;
        if (cmd == CMD_LOAD) begin
            if (m_loaded >= STORE_SIZE) begin
                m_overflow = 1'b1;
                return;
            end
            // count lowered mid-set: position wraps
            if (m_pos >= fc) m_pos = 0;
            p = m_pos;
            m_store[m_loaded] = x;
            m_loaded++;
            if (x > m_max[p]) m_max[p] = x;
            if (x < m_min[p]) m_min[p] = x;
            m_pos = (p + 1 >= fc) ? 0 : p + 1;
        end else begin
            if (m_readout >= m_loaded) return;
            idx = m_readout;
            xv  = m_store[idx];
            mn  = m_min[idx % fc];
            mx  = m_max[idx % fc];
            r.scaled = '0;
            if (mx > mn) begin
                rng = mx - mn;
                if (xv >= mx) begin
                    r.scaled = SCALE_ONE;
                end else if (xv > mn) begin
                    q = ((xv - mn) * 65535 + rng / 2) / rng;
                    r.scaled = (q > 65535) ? SCALE_ONE : q[15:0];
                end
            end
            r.fidx    = 4'(idx % fc);
            r.last    = (idx + 1 == m_loaded);
            r.dropped = m_overflow;
            norm_results_q = {norm_results_q, r};
            m_readout++;
            if (r.last) clear_set();
        end
    endtask

    // ---------------- stimulus queue ----------------
    task automatic push_load(input logic signed [15:0] v);
        t_beat b;
        b.op   = OP_LOAD;
        b.smp  = v;
        b.cfg  = '0;
        b.hold = 1'b0;
        beats_q = {beats_q, b};
        n_items++;
    endtask

    task automatic push_read(input bit hold = 1'b0);
        t_beat b;
        b.op   = OP_READ;
        b.smp  = 16'($urandom);
        b.cfg  = '0;
        b.hold = hold;
        beats_q = {beats_q, b};
        n_items++;
    endtask

    task automatic push_cfg(input logic [CFG_W-1:0] v);
        t_beat b;
        b.op   = OP_CFG;
        b.smp  = '0;
        b.cfg  = v;
        b.hold = 1'b0;
        beats_q = {beats_q, b};
    endtask

    function automatic logic [CFG_W-1:0] pick_count();
        unique case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd31;
            2: return 5'd1;
            3: return 5'd16;
            4: return 5'($urandom_range(17, 30));
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample(t_smp_mode mode,
                                                       logic signed [15:0] base);
        unique case (mode)
            SM_FULL: return 16'($urandom);
            SM_NEAR: return base + 16'($urandom_range(0, 7));
            SM_FLAT: return base;
            default: begin
                unique case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return -16'sd1;
                    default: return 16'sd0;
                endcase
            end
        endcase
    endfunction

    initial begin
        int unsigned        set_len;
        int unsigned        rd_cnt;
        int unsigned        roll;
        t_smp_mode          mode;
        logic signed [15:0] base;

        // two features: full-scale span on feature 0, flat feature 1, then an empty read-out
        push_cfg(5'd2);
        push_load(16'sh8000);
        push_load(16'sd7);
        push_load(16'sh7FFF);
        push_load(16'sd7);
        push_load(16'sd1);
        repeat (5) push_read();
        push_read();
        // lower the count mid-set: load position wraps and read-outs saturate
        push_cfg(5'd3);
        push_load(16'sd100);
        push_load(-16'sd100);
        push_load(16'sd300);
        push_load(16'sd50);
        push_cfg(5'd1);
        push_load(16'sd0);
        repeat (5) push_read();

        // backpressure set: the sink stalls during the read-outs
        push_cfg(5'd4);
        repeat (30) push_load(16'($urandom));
        for (int i = 0; i < 30; i++) push_read(i == 2);

        while (n_items < RAND_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) push_cfg(pick_count());
            set_len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 24);
            mode = t_smp_mode'($urandom_range(0, 3));
            base = 16'($urandom);
            if (roll >= 85) begin
                // loose mix of loads and read-outs
                repeat (set_len) begin
                    if ($urandom_range(0, 2) == 0) push_read();
                    else push_load(pick_sample(mode, base));
                end
            end else begin
                for (int i = 0; i < set_len; i++) begin
                    push_load(pick_sample(mode, base));
                    if (i == set_len / 2 && $urandom_range(0, 9) == 0) push_cfg(pick_count());
                end
                rd_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, set_len) : set_len;
                repeat (rd_cnt) push_read();
                if ($urandom_range(0, 7) == 0) push_read();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_q.size() != 0 || i_valid || norm_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ---------------- driver ----------------
    t_beat       tx_cur;
    logic        tx_busy;
    logic        tx_launch;
    logic        tx_we;
    int unsigned tx_gap   = 0;
    int unsigned tx_quiet = 0;
    int unsigned tx_phase = 0;
    bit          tx_rush  = 1'b0;
    logic        hold_req = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cmd       <= CMD_LOAD;
            i_sample    <= '0;
            i_cfg_we    <= 1'b0;
            i_cfg_wdata <= '0;
            hold_req    <= 1'b0;
            tx_gap   = 0;
            tx_quiet = 0;
            m_fcount = 5'd1;
            clear_set();
        end else begin
            tx_busy   = i_valid;
            tx_launch = 1'b0;
            tx_we     = 1'b0;
            if (++tx_phase == 300) begin
                tx_phase = 0;
                tx_rush  = ($urandom_range(0, 3) == 0);
            end
            if (i_valid && o_ready) begin
                normalize_beat(i_cmd, i_sample);
                if (tx_cur.hold) hold_req <= 1'b1;
                tx_busy  = 1'b0;
                tx_quiet = 0;
            end else if (tx_quiet < SETTLE_CYCLES) begin
                tx_quiet++;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (beats_q.size() > 0) begin
                    if (beats_q[0].op == OP_CFG) begin
                        // register writes only once the block has drained
                        if (norm_results_q.size() == 0 && tx_quiet >= SETTLE_CYCLES) begin
                            tx_cur   = beats_q.pop_front();
                            tx_we    = 1'b1;
                            m_fcount = tx_cur.cfg;
                        end
                    end else begin
                        tx_cur    = beats_q.pop_front();
                        tx_busy   = 1'b1;
                        tx_launch = 1'b1;
                        tx_gap    = (tx_rush || $urandom_range(0, 1)) ? 0 : gap_len();
                    end
                end
            end
            i_valid  <= tx_busy;
            i_cfg_we <= tx_we;
            if (tx_we) i_cfg_wdata <= tx_cur.cfg;
            if (tx_launch) begin
                i_cmd    <= (tx_cur.op == OP_READ) ? CMD_READ : CMD_LOAD;
                i_sample <= tx_cur.smp;
            end
        end
    end

    // ---------------- sink ready ----------------
    int unsigned rx_stall = 0;
    int unsigned rx_hold  = 0;
    int unsigned rx_phase = 0;
    bit          rx_held  = 1'b0;
    bit          rx_rush  = 1'b0;
    logic        rx_rdy;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (++rx_phase == 300) begin
                rx_phase = 0;
                rx_rush  = ($urandom_range(0, 3) == 0);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rx_rdy = 1'b0;
            end else if (hold_req && !rx_held) begin
                // long stall so the block backs up into its input
                rx_held = 1'b1;
                rx_hold = HOLD_CYCLES;
                rx_rdy  = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                rx_rdy = 1'b0;
            end else if (!rx_rush && $urandom_range(0, 99) < 25) begin
                rx_stall = gap_len();
                rx_rdy   = 1'b0;
            end else begin
                rx_rdy = 1'b1;
            end
            i_ready <= rx_rdy;
        end
    end

    // ---------------- monitor ----------------
    t_norm_res exp_res;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (norm_results_q.size() == 0) begin
                $error("result beat with none expected: scaled_value %0d", o_scaled_value);
                err_cnt++;
            end else begin
                exp_res = norm_results_q.pop_front();
                if (o_scaled_value !== exp_res.scaled) begin
                    $error("scaled_value: expected %0d, got %0d", exp_res.scaled,
                           o_scaled_value);
                    err_cnt++;
                end
                if (o_feature_index !== exp_res.fidx) begin
                    $error("feature_index: expected %0d, got %0d", exp_res.fidx,
                           o_feature_index);
                    err_cnt++;
                end
                if (o_last_value !== exp_res.last) begin
                    $error("last_value: expected %0d, got %0d", exp_res.last, o_last_value);
                    err_cnt++;
                end
                if (o_dropped !== exp_res.dropped) begin
                    $error("dropped: expected %0d, got %0d", exp_res.dropped, o_dropped);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int unsigned wdog = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) wdog = 0;
            else wdog++;
            if (wdog == WDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
